>>> rtl/mpqu_pkg.sv
// Package for the unique-value max-priority queue.
// Holds sizes, command codes, controller states and the control/status structs.
// No dependencies.
`default_nettype none

package mpqu_pkg;

    localparam int CAPACITY    = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;
    localparam int CMD_W       = 2;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic scan;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic             scan_done;
        logic             out_hold;
        logic [CNT_W-1:0] stored_count;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/mpqu_cmd_if.sv
// Command channel of the queue: valid/ready handshake with command and value.
// Depends on mpqu_pkg for the field widths.
`default_nettype none

interface mpqu_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [mpqu_pkg::CMD_W-1:0]          command;
    logic signed [mpqu_pkg::VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/mpqu_res_if.sv
// Result channel of the queue: valid/ready handshake with status and top value.
// Depends on mpqu_pkg for the field widths.
`default_nettype none

interface mpqu_res_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [mpqu_pkg::VALUE_W-1:0] top_value;
    logic                                is_empty;
    logic [mpqu_pkg::COUNT_OUT_W-1:0]    entry_count;

    modport source (output valid, output ok, output top_value, output is_empty,
                    output entry_count, input ready);
    modport sink (input valid, input ok, input top_value, input is_empty,
                  input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/max_priority_queue_unique_core.sv
// Top level of the unique-value max-priority queue: controller plus datapath.
// Items are handled one at a time; the scan reads one RAM slot a cycle.
// The result is registered in the finish state, after the scan of the store.
// The next item is accepted while a finished result still waits to be taken.
// Reset clears all valid bits and the count at once; the value RAM is not cleared.
`default_nettype none

module max_priority_queue_unique_core (
    input wire logic   clk,
    input wire logic   rst_n,
    mpqu_cmd_if.sink   request,
    mpqu_res_if.source result
);

    mpqu_pkg::ctrl_t ctrl;
    mpqu_pkg::stat_t stat;

    mpqu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    mpqu_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stat    (stat),
        .request (request),
        .result  (result)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.stored_count <= mpqu_pkg::CNT_W'(mpqu_pkg::CAPACITY))
        else $error("Stored count exceeds capacity.");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.is_empty |-> result.top_value == '0)
        else $error("Empty result carries a nonzero top value.");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready)
        else $error("Second item accepted while one is in flight.");

endmodule

`default_nettype wire

>>> rtl/mpqu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mpqu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/mpqu_ctrl.sv
// Controller state machine of the queue: accept, scan the store, finish.
// Depends on mpqu_pkg for the state type and the control/status structs.
`default_nettype none

module mpqu_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire mpqu_pkg::stat_t stat,
    output mpqu_pkg::ctrl_t      ctrl
);

    mpqu_pkg::state_t state_reg;
    mpqu_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpqu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpqu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mpqu_pkg::ST_SCAN;
                end
            end
            mpqu_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = mpqu_pkg::ST_FINISH;
                end
            end
            mpqu_pkg::ST_FINISH:
            begin
                if (!stat.out_hold)
                begin
                    state_next = mpqu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpqu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            mpqu_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.load     = in_valid;
            end
            mpqu_pkg::ST_SCAN:
            begin
                ctrl.scan = 1'b1;
            end
            mpqu_pkg::ST_FINISH:
            begin
                ctrl.finish = !stat.out_hold;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/mpqu_dp.sv
// Datapath of the queue: value RAM, valid bits, count, scan trackers, result register.
// Depends on mpqu_pkg, mpqu_cmd_if, mpqu_res_if and mpqu_ram.
`default_nettype none

module mpqu_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mpqu_pkg::ctrl_t ctrl,
    output mpqu_pkg::stat_t      stat,
    mpqu_cmd_if.sink             request,
    mpqu_res_if.source           result
);

    localparam int IDX_W = mpqu_pkg::IDX_W;
    localparam int CNT_W = mpqu_pkg::CNT_W;
    localparam int VW    = mpqu_pkg::VALUE_W;
    localparam int OCW   = mpqu_pkg::COUNT_OUT_W;

    // Command and payload of the item in flight.
    mpqu_pkg::cmd_t          cmd_reg, cmd_next;
    logic signed [VW-1:0]    val_reg, val_next;

    // Store state.
    logic [mpqu_pkg::CAPACITY-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]              count_reg, count_next;

    // Scan pipeline: read issue and compare stages.
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    // Scan trackers.
    logic                 match_reg, match_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 any_reg, any_next;
    logic signed [VW-1:0] best_reg, best_next;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg, out_ok_next;
    logic signed [VW-1:0] out_top_reg, out_top_next;
    logic                 out_empty_reg, out_empty_next;
    logic [OCW-1:0]       out_count_reg, out_count_next;

    logic                 issue;
    logic                 ram_we;
    logic [VW-1:0]        ram_rdata;
    logic                 cmp_live;
    logic                 cmp_same;
    logic                 ins_ok;
    logic [CNT_W+OCW-1:0] count_wide;

    assign issue    = ctrl.scan && (rd_idx_reg < CNT_W'(mpqu_pkg::CAPACITY));
    assign cmp_live = valid_reg[cmp_idx_reg];
    assign cmp_same = (ram_rdata == val_reg);
    assign ins_ok   = !match_reg && (count_reg < CNT_W'(mpqu_pkg::CAPACITY));
    assign ram_we   = ctrl.finish && (cmd_reg == mpqu_pkg::CMD_INSERT) && ins_ok;

    mpqu_ram #(
        .WIDTH (VW),
        .DEPTH (mpqu_pkg::CAPACITY)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (val_reg),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_valid_next  = issue;
        cmp_idx_next    = rd_idx_reg[IDX_W-1:0];
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        any_next        = any_reg;
        best_next       = best_reg;
        out_ok_next     = out_ok_reg;
        out_top_next    = out_top_reg;
        out_empty_next  = out_empty_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        count_wide      = '0;

        if (ctrl.load)
        begin
            cmd_next        = mpqu_pkg::cmd_t'(request.command);
            val_next        = request.value;
            rd_idx_next     = '0;
            match_next      = 1'b0;
            free_found_next = 1'b0;
            any_next        = 1'b0;
        end

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end

        if (cmp_valid_reg)
        begin
            if (cmp_live && cmp_same)
            begin
                match_next     = 1'b1;
                match_idx_next = cmp_idx_reg;
            end
            if (!cmp_live && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            // The value named by a remove is left out of the maximum.
            if (cmp_live && !(cmd_reg == mpqu_pkg::CMD_REMOVE && cmp_same))
            begin
                if (!any_reg || ($signed(ram_rdata) > best_reg))
                begin
                    best_next = $signed(ram_rdata);
                end
                any_next = 1'b1;
            end
        end

        if (ctrl.finish)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = 1'b1;
            out_top_next   = any_reg ? best_reg : '0;
            case (cmd_reg)
                mpqu_pkg::CMD_INSERT:
                begin
                    out_ok_next = ins_ok;
                    if (ins_ok)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                        count_next               = count_reg + CNT_W'(1);
                        if (!any_reg || (val_reg > best_reg))
                        begin
                            out_top_next = val_reg;
                        end
                    end
                end
                mpqu_pkg::CMD_REMOVE:
                begin
                    out_ok_next = match_reg;
                    if (match_reg)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                        count_next                = count_reg - CNT_W'(1);
                    end
                end
                mpqu_pkg::CMD_PEEK:
                begin
                    out_ok_next = 1'b1;
                end
                mpqu_pkg::CMD_CLEAR:
                begin
                    valid_next   = '0;
                    count_next   = '0;
                    out_top_next = '0;
                end
                default:
                begin
                    out_ok_next = 1'b1;
                end
            endcase
            count_wide     = {{OCW{1'b0}}, count_next};
            out_count_next = count_wide[OCW-1:0];
            out_empty_next = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        cmp_idx_reg    <= cmp_idx_next;
        match_reg      <= match_next;
        match_idx_reg  <= match_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        any_reg        <= any_next;
        best_reg       <= best_next;
        out_ok_reg     <= out_ok_next;
        out_top_reg    <= out_top_next;
        out_empty_reg  <= out_empty_next;
        out_count_reg  <= out_count_next;
    end

    assign request.ready      = ctrl.in_ready;
    assign result.valid       = out_valid_reg;
    assign result.ok          = out_ok_reg;
    assign result.top_value   = out_top_reg;
    assign result.is_empty    = out_empty_reg;
    assign result.entry_count = out_count_reg;

    assign stat.scan_done    = ctrl.scan && !issue && !cmp_valid_reg;
    assign stat.out_hold     = out_valid_reg && !result.ready;
    assign stat.stored_count = count_reg;

endmodule

`default_nettype wire

>>> tb/sv/max_priority_queue_unique_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for max_priority_queue_unique_core: a directed table, then random commands.
// Results are predicted by an in-bench model of the store and compared field by field.
// Depends on mpqu_pkg, mpqu_cmd_if, mpqu_res_if and the core itself.

module max_priority_queue_unique_core_tb;

    import mpqu_pkg::*;

    localparam int RANDOM_ITEMS     = 1000;
    localparam int POOL_SIZE        = 24;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER  = 300;
    localparam int DRAIN_CYCLES     = 2 * (CAPACITY + 4);

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                     ok;
        logic signed [VALUE_W-1:0] top_value;
        logic                     is_empty;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } queue_result_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        queue_result_t             typed_result;
    } directed_row_t;

    logic clk;
    logic rst_n;

    mpqu_cmd_if cmd_ch ();
    mpqu_res_if res_ch ();

    max_priority_queue_unique_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(cmd_ch),
        .result (res_ch)
    );

    logic signed [VALUE_W-1:0] slot_value [CAPACITY];
    bit                        slot_used  [CAPACITY];
    int                        held_count;

    queue_result_t             pending_results [$];
    logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];

    int error_count    = 0;
    int results_taken  = 0;
    int cmd_count [4]  = '{0, 0, 0, 0};
    int refused_count  = 0;
    int full_inserts   = 0;
    bit sender_steady  = 0;
    bit receiver_steady = 0;
    bit long_hold_done = 0;

    directed_row_t directed_rows [26] = '{
        '{CMD_PEEK,   32'sd0,          1'b1, '{1'b1, 32'sd0,  1'b1, 5'd0}},
        '{CMD_REMOVE, 32'sd5,          1'b1, '{1'b0, 32'sd0,  1'b1, 5'd0}},
        '{CMD_CLEAR,  32'sd0,          1'b1, '{1'b1, 32'sd0,  1'b1, 5'd0}},
        '{CMD_INSERT, VAL_MIN,         1'b1, '{1'b1, VAL_MIN, 1'b0, 5'd1}},
        '{CMD_INSERT, VAL_MIN,         1'b1, '{1'b0, VAL_MIN, 1'b0, 5'd1}},
        '{CMD_INSERT, VAL_MAX,         1'b1, '{1'b1, VAL_MAX, 1'b0, 5'd2}},
        '{CMD_INSERT, -32'sd1,         1'b0, '0},
        '{CMD_INSERT, 32'sd0,          1'b0, '0},
        '{CMD_INSERT, 32'sd1,          1'b0, '0},
        '{CMD_PEEK,   32'sh1234_5678,  1'b0, '0},
        '{CMD_REMOVE, VAL_MAX,         1'b0, '0},
        '{CMD_REMOVE, VAL_MAX,         1'b0, '0},
        '{CMD_INSERT, 32'sh5555_5555,  1'b0, '0},
        '{CMD_INSERT, 32'shAAAA_AAAA,  1'b0, '0},
        '{CMD_INSERT, 32'sh0F0F_0F0F,  1'b0, '0},
        '{CMD_INSERT, 32'shF0F0_F0F0,  1'b0, '0},
        '{CMD_INSERT, 32'sh3333_3333,  1'b0, '0},
        '{CMD_INSERT, 32'shCCCC_CCCC,  1'b0, '0},
        '{CMD_INSERT, 32'sd2,          1'b0, '0},
        '{CMD_INSERT, -32'sd2,         1'b0, '0},
        '{CMD_INSERT, 32'sh7FFF_FFFE,  1'b0, '0},
        '{CMD_INSERT, 32'sh8000_0001,  1'b0, '0},
        '{CMD_INSERT, 32'sd1000,       1'b0, '0},
        '{CMD_INSERT, -32'sd1000,      1'b0, '0},
        '{CMD_INSERT, 32'sd7,          1'b0, '0},
        '{CMD_CLEAR,  32'shFFFF_FFFF,  1'b1, '{1'b1, 32'sd0,  1'b1, 5'd0}}
    };

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic queue_result_t apply_command(input cmd_t cmd,
                                                    input logic signed [VALUE_W-1:0] val);
        queue_result_t             res;
        int                        hit;
        int                        free_idx;
        logic signed [VALUE_W-1:0] best;
        bit                        any;
        res.ok   = 1'b1;
        hit      = -1;
        free_idx = -1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot_used[i] && slot_value[i] == val && hit < 0)
                hit = i;
            if (!slot_used[i] && free_idx < 0)
                free_idx = i;
        end
        case (cmd)
            CMD_INSERT:
            begin
                if (hit >= 0 || held_count >= CAPACITY || free_idx < 0)
                    res.ok = 1'b0;
                else
                begin
                    slot_value[free_idx] = val;
                    slot_used[free_idx]  = 1'b1;
                    held_count++;
                end
            end
            CMD_REMOVE:
            begin
                if (hit < 0)
                    res.ok = 1'b0;
                else
                begin
                    slot_used[hit] = 1'b0;
                    held_count--;
                end
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    slot_used[i] = 1'b0;
                held_count = 0;
            end
            default:
            begin
            end
        endcase
        best = '0;
        any  = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot_used[i] && (!any || slot_value[i] > best))
            begin
                best = slot_value[i];
                any  = 1'b1;
            end
        end
        res.top_value   = best;
        res.is_empty    = (held_count == 0);
        res.entry_count = COUNT_OUT_W'(held_count);
        return res;
    endfunction

    // Mostly no gap, some short ones and a few long ones.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_command(input cmd_t cmd, input logic signed [VALUE_W-1:0] val,
                                input bit use_typed, input queue_result_t typed_result);
        int            gap;
        queue_result_t predicted;
        gap = sender_steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.value   <= val;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (cmd == CMD_INSERT && held_count == CAPACITY)
            full_inserts++;
        predicted = apply_command(cmd, val);
        cmd_count[cmd]++;
        if (!predicted.ok)
            refused_count++;
        pending_results.push_back(use_typed ? typed_result : predicted);
    endtask

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_taken++;
            if (pending_results.size() == 0)
            begin
                $error("result with no command waiting for it");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, res_ch.ok);
                    error_count++;
                end
                if (res_ch.top_value !== want.top_value)
                begin
                    $error("top_value: expected %0d, got %0d", want.top_value,
                           res_ch.top_value);
                    error_count++;
                end
                if (res_ch.is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, res_ch.is_empty);
                    error_count++;
                end
                if (res_ch.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           res_ch.entry_count);
                    error_count++;
                end
            end
        end
    end

    // The receiver holds off once for a long stretch so the block backs up and stalls its input.
    initial
    begin
        int burst;
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_taken >= LONG_HOLD_AFTER)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    receiver_steady = !receiver_steady;
                burst = $urandom_range(1, 20);
                res_ch.ready <= 1'b1;
                repeat (burst) @(posedge clk);
                stall = receiver_steady ? 0 : idle_gap();
                if (stall > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int                        r;
        cmd_t                      cmd;
        logic signed [VALUE_W-1:0] val;
        clk            = 1'b0;
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_PEEK;
        cmd_ch.value   <= '0;
        held_count     = 0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_value[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(directed_rows); i++)
            send_command(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].typed,
                         directed_rows[i].typed_result);

        // A small reused pool of values makes duplicates, hits on remove and a full store common.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                for (int k = 0; k < POOL_SIZE; k++)
                begin
                    case ($urandom_range(0, 11))
                        0:       value_pool[k] = VAL_MIN;
                        1:       value_pool[k] = VAL_MAX;
                        2:       value_pool[k] = $urandom_range(0, 3) - 2;
                        default: value_pool[k] = $urandom;
                    endcase
                end
            end
            if (n % 100 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 52)
                cmd = CMD_INSERT;
            else if (r < 88)
                cmd = CMD_REMOVE;
            else if (r < 98)
                cmd = CMD_PEEK;
            else
                cmd = CMD_CLEAR;
            if ($urandom_range(0, 99) < 80)
                val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                val = $urandom;
            send_command(cmd, val, 1'b0, '0);
        end
        cmd_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d directed and %0d random commands: %0d inserts, %0d removes,",
                 $size(directed_rows), RANDOM_ITEMS, cmd_count[CMD_INSERT],
                 cmd_count[CMD_REMOVE]);
        $display("%0d peeks, %0d clears; %0d refused, %0d inserts against a full store.",
                 cmd_count[CMD_PEEK], cmd_count[CMD_CLEAR], refused_count, full_inserts);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
